// ----- rtl/modem_reply_keyword_watcher_macros.svh -----
// Assertion macros for the checker file of the keyword watcher.
`ifndef MODEM_REPLY_KEYWORD_WATCHER_MACROS_SVH
`define MODEM_REPLY_KEYWORD_WATCHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define MRKW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyword watcher check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define MRKW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyword watcher check failed");

`endif

// ----- rtl/mrkw_pkg.sv -----
// Package: item codes, keyword tables and the matcher step function.
`timescale 1ns / 1ps
`default_nettype none

package mrkw_pkg;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int KW_NUM      = 5;

   // Bit positions in the clear mask.
   localparam int CLR_FAIL    = 0;
   localparam int CLR_ERROR   = 1;
   localparam int CLR_CLOSED  = 2;
   localparam int CLR_PENDING = 3;

   typedef enum logic [1:0] {
      FUNC_BYTE  = 2'd0,
      FUNC_ARM   = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      KW_PREFIX = 3'd0,
      KW_FAIL   = 3'd1,
      KW_ERROR  = 3'd2,
      KW_CLOSED = 3'd3,
      KW_OK     = 3'd4
   } kw_type;

   typedef struct packed {
      logic [2:0] count;
      logic       done;
   } track_type;

   function automatic logic [2:0] kw_len(input kw_type kw);
      case (kw)
         KW_PREFIX: kw_len = 3'd7;
         KW_FAIL:   kw_len = 3'd4;
         KW_ERROR:  kw_len = 3'd5;
         KW_CLOSED: kw_len = 3'd6;
         KW_OK:     kw_len = 3'd4;
         default:   kw_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input kw_type kw, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (kw)
         KW_PREFIX: begin
            case (pos)
               3'd0: c = "+";
               3'd1: c = "I";
               3'd2: c = "P";
               3'd3: c = "D";
               3'd4: c = ",";
               3'd5: c = "1";
               3'd6: c = ":";
               default: c = 8'h00;
            endcase
         end
         KW_FAIL: begin
            case (pos)
               3'd0: c = "F";
               3'd1: c = "A";
               3'd2: c = "I";
               3'd3: c = "L";
               default: c = 8'h00;
            endcase
         end
         KW_ERROR: begin
            case (pos)
               3'd0: c = "E";
               3'd1: c = "R";
               3'd2: c = "R";
               3'd3: c = "O";
               3'd4: c = "R";
               default: c = 8'h00;
            endcase
         end
         KW_CLOSED: begin
            case (pos)
               3'd0: c = "C";
               3'd1: c = "L";
               3'd2: c = "O";
               3'd3: c = "S";
               3'd4: c = "E";
               3'd5: c = "D";
               default: c = 8'h00;
            endcase
         end
         KW_OK: begin
            case (pos)
               3'd0: c = "O";
               3'd1: c = "K";
               3'd2: c = 8'h0D;
               3'd3: c = 8'h0A;
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // One matcher step: advance on the expected character, else drop to zero.
   // A counter already at full length never matches, so it drops too.
   function automatic track_type kw_track(input logic [2:0] cnt, input kw_type kw,
                                          input logic [7:0] b);
      track_type r;
      r.count = 3'd0;
      r.done  = 1'b0;
      if ((cnt < kw_len(kw)) && (b == kw_char(kw, cnt))) begin
         r.count = cnt + 3'd1;
         r.done  = (r.count == kw_len(kw));
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/modem_reply_keyword_watcher.sv -----
// Top level: modem reply keyword watcher with stream input and result channels.
`timescale 1ns / 1ps
`default_nettype none

// Watches received modem bytes for "+IPD,1:", FAIL, ERROR, CLOSED and OK CR LF.
// Every request beat (tuser = func: 0 byte, 1 arm OK matcher, 2 clear flags)
// yields exactly one response beat that shows the flags after that item.
// A mismatching byte sends a matcher back to zero without being retried as a
// first character; a matcher at full length treats the next byte as a mismatch.
// The byte after a full data prefix is captured and raises capture_pending.
// The OK matcher starts armed after reset and disarms itself on a full match.
// Rate: one item per clock while rsp_tready does not stall the result register.
// The input register takes the request beat, and the matcher update then moves
// into the result register, which drives rsp_tvalid, once that register is
// free or drains.
// The input register refills while a finished result waits, so one stalled
// response does not stop the request side at once.
module modem_reply_keyword_watcher (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] rx_byte, [11:8] clear_mask, [15:12] zero
   input  wire logic [mrkw_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [mrkw_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] fail_seen, [1] error_seen, [2] closed_seen, [3] capture_pending,
   // [11:4] captured_byte, [12] ok_waiting, [15:13] zero
   output logic [mrkw_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import mrkw_pkg::*;

   // Input register.
   logic       s1_valid_ff;
   logic [1:0] s1_func_ff;
   logic [7:0] s1_byte_ff;
   logic [3:0] s1_mask_ff;

   // Result register.
   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic [RSP_TDATA_W-1:0] out_data_in;

   // Matcher state.
   logic [2:0] cnt_ff [KW_NUM];
   logic [2:0] cnt_in [KW_NUM];
   logic       capture_armed_ff, capture_armed_in;
   logic       pending_ff, pending_in;
   logic       fail_ff, fail_in;
   logic       error_ff, error_in;
   logic       closed_ff, closed_in;
   logic       ok_armed_ff, ok_armed_in;
   logic [7:0] held_ff, held_in;

   logic              advance;
   logic [KW_NUM-1:0] kw_done;
   track_type         tr [KW_NUM];

   // Move the held item into the result register when that register is free
   // or drains this cycle; refill the input register behind it.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      for (int k = 0; k < KW_NUM; k++) begin
         tr[k] = kw_track(cnt_ff[k], kw_type'(k), s1_byte_ff);
      end
   end

   always_comb begin
      for (int k = 0; k < KW_NUM; k++) begin
         cnt_in[k] = cnt_ff[k];
      end
      kw_done          = '0;
      capture_armed_in = capture_armed_ff;
      pending_in       = pending_ff;
      fail_in          = fail_ff;
      error_in         = error_ff;
      closed_in        = closed_ff;
      ok_armed_in      = ok_armed_ff;
      held_in          = held_ff;
      case (func_type'(s1_func_ff))
         FUNC_BYTE: begin
            // Capture the byte after a full prefix before the matchers run.
            if (capture_armed_ff) begin
               held_in          = s1_byte_ff;
               capture_armed_in = 1'b0;
               pending_in       = 1'b1;
            end
            for (int k = 0; k < KW_NUM; k++) begin
               // Hold the OK counter while its matcher is disarmed.
               if ((k != int'(KW_OK)) || ok_armed_ff) begin
                  cnt_in[k]  = tr[k].count;
                  kw_done[k] = tr[k].done;
               end
            end
            if (kw_done[KW_PREFIX]) capture_armed_in = 1'b1;
            if (kw_done[KW_FAIL])   fail_in          = 1'b1;
            if (kw_done[KW_ERROR])  error_in         = 1'b1;
            if (kw_done[KW_CLOSED]) closed_in        = 1'b1;
            if (kw_done[KW_OK])     ok_armed_in      = 1'b0;
         end
         FUNC_ARM: begin
            ok_armed_in = 1'b1;
         end
         FUNC_CLEAR: begin
            if (s1_mask_ff[CLR_FAIL])    fail_in    = 1'b0;
            if (s1_mask_ff[CLR_ERROR])   error_in   = 1'b0;
            if (s1_mask_ff[CLR_CLOSED])  closed_in  = 1'b0;
            if (s1_mask_ff[CLR_PENDING]) pending_in = 1'b0;
         end
         default: begin
            // Unused code: report the state unchanged.
         end
      endcase
      out_data_in = {3'b000, ok_armed_in, held_in, pending_in, closed_in, error_in, fail_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_func_ff <= req_tuser[1:0];
         s1_byte_ff <= req_tdata[7:0];
         s1_mask_ff <= req_tdata[11:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KW_NUM; k++) begin
            cnt_ff[k] <= 3'd0;
         end
         capture_armed_ff <= 1'b0;
         pending_ff       <= 1'b0;
         fail_ff          <= 1'b0;
         error_ff         <= 1'b0;
         closed_ff        <= 1'b0;
         ok_armed_ff      <= 1'b1;
         held_ff          <= 8'h00;
      end else if (advance) begin
         for (int k = 0; k < KW_NUM; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
         capture_armed_ff <= capture_armed_in;
         pending_ff       <= pending_in;
         fail_ff          <= fail_in;
         error_ff         <= error_in;
         closed_ff        <= closed_in;
         ok_armed_ff      <= ok_armed_in;
         held_ff          <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mrkw_checker.sv -----
// Port-level checker for the keyword watcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "modem_reply_keyword_watcher_macros.svh"

module mrkw_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [mrkw_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mrkw_pkg::*;

   logic [2:0] outstanding_ff;
   logic [2:0] outstanding_in;
   logic [7:0] prev_byte_ff;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_beat && !rsp_beat) outstanding_in = outstanding_ff + 3'd1;
      if (!req_beat && rsp_beat) outstanding_in = outstanding_ff - 3'd1;
   end

   // Track items in flight and the captured byte of the last response beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 3'd0;
         prev_byte_ff   <= 8'h00;
      end else begin
         outstanding_ff <= outstanding_in;
         if (rsp_beat) prev_byte_ff <= rsp_tdata[11:4];
      end
   end

   `MRKW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `MRKW_ASSERT_NOW(a_depth, 1'b1, outstanding_ff <= 3'd2)
   `MRKW_ASSERT_NOW(a_no_invented, rsp_tvalid, outstanding_ff != 3'd0)
   `MRKW_ASSERT_NOW(a_capture_flag, rsp_tvalid && (rsp_tdata[11:4] != prev_byte_ff), rsp_tdata[3])

endmodule

bind modem_reply_keyword_watcher mrkw_checker u_checker (.*);

`default_nettype wire

// ----- sim/tb_modem_reply_keyword_watcher.sv -----
// Testbench for the keyword watcher: directed and random stream traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_modem_reply_keyword_watcher;
   import mrkw_pkg::*;

   // The func code that the block ignores: it only reports the current flags.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Keyword texts, first character in the highest byte.
   localparam logic [55:0] PREFIX_TEXT = "+IPD,1:";
   localparam logic [31:0] FAIL_TEXT   = "FAIL";
   localparam logic [39:0] ERROR_TEXT  = "ERROR";
   localparam logic [47:0] CLOSED_TEXT = "CLOSED";
   localparam logic [31:0] OK_TEXT     = {"OK", 8'h0D, 8'h0A};

   localparam int SHOWN_FAILURES = 10;
   localparam int DRAIN_CYCLES   = 10;

   // One request beat as the sender sees it.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
      logic [3:0] clear_mask;
   } watcher_item_type;

   // Flags of one response beat; packed so that fail_seen lands in bit 0.
   typedef struct packed {
      logic       ok_waiting;
      logic [7:0] captured_byte;
      logic       capture_pending;
      logic       closed_seen;
      logic       error_seen;
      logic       fail_seen;
   } watcher_flags_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   modem_reply_keyword_watcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Items waiting to go out, and the flags each accepted item must produce.
   watcher_item_type  items_to_send[$];
   watcher_flags_type expected_flags[$];
   watcher_item_type  drive_item;
   watcher_flags_type got_flags;
   watcher_flags_type want_flags;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_sent    = 0;
   int beats_checked = 0;
   int fail_count    = 0;
   int keyword_hits[0:KW_NUM-1] = '{default: 0};

   // Predicted state of the watcher.
   logic [2:0] watch_pos[0:KW_NUM-1] = '{default: 3'd0};
   logic       watch_capture_armed   = 1'b0;
   logic       watch_pending         = 1'b0;
   logic       watch_fail            = 1'b0;
   logic       watch_error           = 1'b0;
   logic       watch_closed          = 1'b0;
   logic       watch_ok_armed        = 1'b1;
   logic [7:0] watch_held_byte       = 8'h00;

   function automatic logic [2:0] keyword_length(input kw_type kw);
      case (kw)
         KW_PREFIX: return 3'd7;
         KW_FAIL:   return 3'd4;
         KW_ERROR:  return 3'd5;
         KW_CLOSED: return 3'd6;
         KW_OK:     return 3'd4;
         default:   return 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] keyword_char(input kw_type kw, input int pos);
      case (kw)
         KW_PREFIX: return PREFIX_TEXT[8 * (6 - pos) +: 8];
         KW_FAIL:   return FAIL_TEXT[8 * (3 - pos) +: 8];
         KW_ERROR:  return ERROR_TEXT[8 * (4 - pos) +: 8];
         KW_CLOSED: return CLOSED_TEXT[8 * (5 - pos) +: 8];
         KW_OK:     return OK_TEXT[8 * (3 - pos) +: 8];
         default:   return 8'h00;
      endcase
   endfunction

   // Step one keyword position; a miss drops to zero and is not retried as a
   // first character. A position already at full length always misses.
   function automatic logic advance_match(input kw_type kw, input logic [7:0] b);
      logic [2:0] pos;
      pos = watch_pos[kw];
      if (pos < keyword_length(kw) && b == keyword_char(kw, pos)) begin
         watch_pos[kw] = pos + 3'd1;
         if (watch_pos[kw] == keyword_length(kw)) begin
            keyword_hits[kw]++;
            return 1'b1;
         end
         return 1'b0;
      end
      watch_pos[kw] = 3'd0;
      return 1'b0;
   endfunction

   // Apply one accepted item to the predicted state and return the flags after it.
   function automatic watcher_flags_type predict_watcher_flags(input watcher_item_type it);
      watcher_flags_type f;
      if (it.func == FUNC_BYTE) begin
         // The byte after a full prefix is latched before the matchers see it.
         if (watch_capture_armed) begin
            watch_held_byte     = it.rx_byte;
            watch_capture_armed = 1'b0;
            watch_pending       = 1'b1;
         end
         if (advance_match(KW_PREFIX, it.rx_byte)) watch_capture_armed = 1'b1;
         if (advance_match(KW_FAIL, it.rx_byte)) watch_fail = 1'b1;
         if (advance_match(KW_ERROR, it.rx_byte)) watch_error = 1'b1;
         if (advance_match(KW_CLOSED, it.rx_byte)) watch_closed = 1'b1;
         // A disarmed OK matcher holds its position and skips the byte.
         if (watch_ok_armed) begin
            if (advance_match(KW_OK, it.rx_byte)) watch_ok_armed = 1'b0;
         end
      end else if (it.func == FUNC_ARM) begin
         watch_ok_armed = 1'b1;
      end else if (it.func == FUNC_CLEAR) begin
         if (it.clear_mask[CLR_FAIL])    watch_fail    = 1'b0;
         if (it.clear_mask[CLR_ERROR])   watch_error   = 1'b0;
         if (it.clear_mask[CLR_CLOSED])  watch_closed  = 1'b0;
         if (it.clear_mask[CLR_PENDING]) watch_pending = 1'b0;
      end
      f.fail_seen       = watch_fail;
      f.error_seen      = watch_error;
      f.closed_seen     = watch_closed;
      f.capture_pending = watch_pending;
      f.captured_byte   = watch_held_byte;
      f.ok_waiting      = watch_ok_armed;
      return f;
   endfunction

   // Stimulus helpers; unused fields carry random values the block must ignore.
   task automatic push_item(input logic [1:0] func, input logic [7:0] b,
                            input logic [3:0] mask);
      watcher_item_type it;
      it.func       = func;
      it.rx_byte    = b;
      it.clear_mask = mask;
      items_to_send.push_back(it);
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_item(FUNC_BYTE, b, 4'($urandom_range(15)));
   endtask

   task automatic push_arm();
      push_item(FUNC_ARM, 8'($urandom_range(255)), 4'($urandom_range(15)));
   endtask

   task automatic push_clear(input logic [3:0] mask);
      push_item(FUNC_CLEAR, 8'($urandom_range(255)), mask);
   endtask

   // Push a keyword; flaw 1 swaps one character, flaw 2 cuts it short.
   // Returns the number of beats pushed.
   task automatic push_keyword(input kw_type kw, input int flaw, output int pushed);
      int len;
      int cut;
      len    = keyword_length(kw);
      cut    = $urandom_range(len - 1);
      pushed = 0;
      for (int i = 0; i < len; i++) begin
         if (flaw == 2 && i == cut) break;
         if (flaw == 1 && i == cut) push_byte(8'($urandom_range(255)));
         else push_byte(keyword_char(kw, i));
         pushed++;
      end
      // Follow a data prefix with the byte to be captured.
      if (kw == KW_PREFIX) begin
         push_byte(8'($urandom_range(255)));
         pushed++;
      end
   endtask

   // Well-formed keywords dominate so every matcher reaches full length;
   // the rest is noise, control beats and broken keywords.
   task automatic push_random_traffic(input int beats);
      int     done_beats;
      int     pick;
      int     pushed;
      int     flaw;
      kw_type kw;
      done_beats = 0;
      while (done_beats < beats) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            kw   = kw_type'($urandom_range(KW_NUM - 1));
            flaw = ($urandom_range(99) < 80) ? 0 : $urandom_range(1, 2);
            push_keyword(kw, flaw, pushed);
            done_beats += pushed;
         end else if (pick < 68) begin
            push_arm();
            done_beats++;
         end else if (pick < 80) begin
            push_clear(4'($urandom_range(15)));
            done_beats++;
         end else if (pick < 83) begin
            // Ignored code: not counted toward the beat budget.
            push_item(FUNC_UNUSED, 8'($urandom_range(255)), 4'($urandom_range(15)));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(1)) begin
                  kw = kw_type'($urandom_range(KW_NUM - 1));
                  push_byte(keyword_char(kw, $urandom_range(keyword_length(kw) - 1)));
               end else begin
                  push_byte(8'($urandom_range(255)));
               end
               done_beats++;
            end
         end
      end
   endtask

   task automatic wait_for_quiet();
      while (items_to_send.size() != 0 || expected_flags.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   // Hold reset from time zero, then release it once.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_modem_reply_keyword_watcher NOT OK");
      $finish;
   end

   // Driver: record the accepted beat, then present the next one or go idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_flags.push_back(predict_watcher_flags(drive_item));
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_item = items_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0000, drive_item.clear_mask, drive_item.rx_byte};
               req_tuser  <= drive_item.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random and compare each response beat with the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got_flags = rsp_tdata[12:0];
            if (expected_flags.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOWN_FAILURES)
                  $display("%0t: response beat with nothing expected, got %h", $realtime,
                           got_flags);
            end else begin
               want_flags = expected_flags.pop_front();
               beats_checked++;
               if (got_flags.fail_seen       !== want_flags.fail_seen ||
                   got_flags.error_seen      !== want_flags.error_seen ||
                   got_flags.closed_seen     !== want_flags.closed_seen ||
                   got_flags.capture_pending !== want_flags.capture_pending ||
                   got_flags.captured_byte   !== want_flags.captured_byte ||
                   got_flags.ok_waiting      !== want_flags.ok_waiting) begin
                  fail_count++;
                  if (fail_count <= SHOWN_FAILURES) begin
                     $write("%0t: beat %0d mismatch: fail %b/%b error %b/%b closed %b/%b ",
                            $realtime, beats_checked,
                            want_flags.fail_seen, got_flags.fail_seen,
                            want_flags.error_seen, got_flags.error_seen,
                            want_flags.closed_seen, got_flags.closed_seen);
                     $display("pending %b/%b byte %h/%h ok_waiting %b/%b (expected/actual)",
                              want_flags.capture_pending, got_flags.capture_pending,
                              want_flags.captured_byte, got_flags.captured_byte,
                              want_flags.ok_waiting, got_flags.ok_waiting);
                  end
               end
            end
         end
      end
   end

   initial begin
      int dummy;
      while (reset) @(negedge clock);

      // Directed part, first phase idling: sender 9 %, receiver 46 %.
      send_idle_pct = 9;
      recv_idle_pct = 46;
      push_item(FUNC_UNUSED, 8'hFF, 4'hF);   // reset state, ignored code
      push_byte(8'h00);
      push_byte(8'hFF);
      push_keyword(KW_FAIL, 0, dummy);
      push_clear(4'b0001);
      // Repeated first character: the second F must not restart the match.
      push_byte("F");
      push_keyword(KW_FAIL, 0, dummy);
      // Full prefix; the captured byte then knocks the prefix back to zero.
      push_keyword(KW_PREFIX, 0, dummy);
      // Reply OK while armed from reset, then arm twice in a row.
      push_keyword(KW_OK, 0, dummy);
      push_arm();
      push_arm();
      push_clear(4'hF);
      wait_for_quiet();

      push_random_traffic(530);
      wait_for_quiet();

      // Swap the idling of the two sides.
      send_idle_pct = 46;
      recv_idle_pct = 9;
      push_random_traffic(530);
      wait_for_quiet();

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random_traffic(530);
      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d request beats and %0d checked responses over three idling mixes",
               beats_sent, beats_checked);
      $display("Keyword completions: prefix %0d, FAIL %0d, ERROR %0d, CLOSED %0d, OK %0d",
               keyword_hits[KW_PREFIX], keyword_hits[KW_FAIL], keyword_hits[KW_ERROR],
               keyword_hits[KW_CLOSED], keyword_hits[KW_OK]);
      if (fail_count == 0 && expected_flags.size() == 0) begin
         $display("tb_modem_reply_keyword_watcher OK");
      end else begin
         $display("%0d failures, %0d responses missing", fail_count, expected_flags.size());
         $display("tb_modem_reply_keyword_watcher NOT OK");
      end
      $finish;
   end

endmodule
